FILE: hdl/epr_pkg.sv
// ---------------------------------------------------------------------------
// epr_pkg: shared types and constants for the echo pulse range capture unit
// Holds the command codes, register indexes, field widths and control types.
// ---------------------------------------------------------------------------
package epr_pkg;

  localparam int CAP_W  = 32;   // captured count / dividend width
  localparam int REG_W  = 16;   // configuration register width
  localparam int DIST_W = 16;   // distance width
  localparam int TIM_W  = 3;
  localparam int CH_W   = 2;
  localparam int IDX_W  = 1;    // two configuration registers
  localparam int DIV_CNT_W = $clog2(CAP_W);

  localparam logic [CAP_W-1:0] NARROW_MASK = 32'h0000_FFFF;
  localparam logic [CAP_W-1:0] WIDE_MASK   = 32'hFFFF_FFFF;

  localparam logic CMD_ARM  = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  localparam logic [IDX_W-1:0] REG_SPEED_FACTOR = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_RANGE    = 1'b1;

  // measurement progress
  typedef enum logic [1:0] {
    PH_RISING  = 2'd0,
    PH_FALLING = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // sequencer state
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_FINISH = 2'd2
  } ctrl_state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: hdl/echo_pulse_range_capture_unit.sv
// ---------------------------------------------------------------------------
// echo_pulse_range_capture_unit: echo pulse width to distance converter
// Arm / edge requests in, one distance result per completed pulse.
// ---------------------------------------------------------------------------
// Arm and non-closing edge requests leave the unit idle, so the next request is
// taken on the following cycle.
// A closing (second matching) edge holds the input through 32 steps in the
// one-bit-per-cycle divider, the registering of its done flag and the load of
// the result; longer while out_stall keeps an earlier result in place.
// rst_n (synchronous, active low) restores speed_factor 58, max_range_cm 400,
// nothing armed, no result pending.
module echo_pulse_range_capture_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [epr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [epr_pkg::REG_W-1:0]     cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [epr_pkg::TIM_W-1:0]     in_timer_id,
  input  logic [epr_pkg::CH_W-1:0]      in_channel,
  input  logic                          in_wide_counter,
  input  logic [epr_pkg::CAP_W-1:0]     in_capture_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [epr_pkg::DIST_W-1:0]    out_distance_cm,
  output logic                          out_in_range
);
  import epr_pkg::*;

  // configuration registers
  logic [REG_W-1:0] speed_factor_r;
  logic [REG_W-1:0] max_range_cm_r;

  // measurement state
  phase_t           phase_r, phase_nxt;
  logic [TIM_W-1:0] armed_timer_r, armed_timer_nxt;
  logic [CH_W-1:0]  armed_channel_r, armed_channel_nxt;
  logic             wrap_is_wide_r, wrap_is_wide_nxt;
  logic [CAP_W-1:0] start_count_r, start_count_nxt;

  // sequencer and result register
  ctrl_state_t      state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic             in_range_r, in_range_nxt;

  // divider hookup
  logic             div_start;
  logic [CAP_W-1:0] div_dividend;
  logic [CAP_W-1:0] div_quotient;
  div_status_t      div_status;

  logic             in_accept;
  logic             out_accept;
  logic             edge_match;
  logic [CAP_W-1:0] cnt_mask;
  logic [CAP_W-1:0] cap_masked;
  logic [CAP_W-1:0] quo_eff;
  logic             out_of_range;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;
  assign in_stall   = (state_r != ST_IDLE);

  assign edge_match = (in_timer_id == armed_timer_r) && (in_channel == armed_channel_r);
  assign cnt_mask   = wrap_is_wide_r ? WIDE_MASK : NARROW_MASK;
  assign cap_masked = in_capture_value & cnt_mask;
  // pulse width modulo the counter period unwraps a single rollover
  assign div_dividend = (cap_masked - start_count_r) & cnt_mask;

  // zero divisor counts as a zero distance
  assign quo_eff      = (speed_factor_r == '0) ? '0 : div_quotient;
  assign out_of_range = (quo_eff == '0) || (quo_eff > {{(CAP_W-REG_W){1'b0}}, max_range_cm_r});

  epr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (speed_factor_r),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_factor_r <= REG_W'(58);
      max_range_cm_r <= REG_W'(400);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SPEED_FACTOR: speed_factor_r <= cfg_data;
        REG_MAX_RANGE:    max_range_cm_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // sequencer: request decode, divide wait, result hand-off
  always_comb begin
    state_nxt         = state_r;
    phase_nxt         = phase_r;
    armed_timer_nxt   = armed_timer_r;
    armed_channel_nxt = armed_channel_r;
    wrap_is_wide_nxt  = wrap_is_wide_r;
    start_count_nxt   = start_count_r;
    out_valid_nxt     = out_valid_r;
    dist_nxt          = dist_r;
    in_range_nxt      = in_range_r;
    div_start         = 1'b0;

    if (out_accept) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_command == CMD_ARM) begin
            armed_timer_nxt   = in_timer_id;
            armed_channel_nxt = in_channel;
            wrap_is_wide_nxt  = in_wide_counter;
            phase_nxt         = PH_RISING;
          end else if (edge_match) begin
            case (phase_r)
              PH_RISING: begin
                start_count_nxt = cap_masked;
                phase_nxt       = PH_FALLING;
              end
              PH_FALLING: begin
                div_start = 1'b1;
                phase_nxt = PH_DONE;
                state_nxt = ST_DIVIDE;
              end
              default: ;  // done: stray edge, no result
            endcase
          end
        end
      end
      ST_DIVIDE: begin
        if (div_status.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // load once the result register is free or draining this cycle
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          in_range_nxt  = !out_of_range;
          dist_nxt      = out_of_range ? max_range_cm_r : quo_eff[DIST_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    in_range_r <= in_range_nxt;
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      phase_r         <= PH_DONE;
      armed_timer_r   <= '0;
      armed_channel_r <= '0;
      wrap_is_wide_r  <= 1'b0;
      start_count_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      phase_r         <= phase_nxt;
      armed_timer_r   <= armed_timer_nxt;
      armed_channel_r <= armed_channel_nxt;
      wrap_is_wide_r  <= wrap_is_wide_nxt;
      start_count_r   <= start_count_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance_cm = dist_r;
  assign out_in_range    = in_range_r;

endmodule

FILE: hdl/epr_divider.sv
// ---------------------------------------------------------------------------
// epr_divider: iterative restoring divider
// 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module epr_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [epr_pkg::CAP_W-1:0]   dividend,
  input  logic [epr_pkg::REG_W-1:0]   divisor,
  output logic [epr_pkg::CAP_W-1:0]   quotient,
  output epr_pkg::div_status_t        status
);
  import epr_pkg::*;

  logic [REG_W-1:0]     rem_r, rem_nxt;
  logic [CAP_W-1:0]     quo_r, quo_nxt;
  logic [REG_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [REG_W:0]   shifted;
  logic [REG_W+1:0] trial;
  logic             ge;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_r, quo_r[CAP_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~trial[REG_W+1];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[REG_W-1:0] : shifted[REG_W-1:0];
      quo_nxt = {quo_r[CAP_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(CAP_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

FILE: tb/echo_range_checker.sv
// ---------------------------------------------------------------------------
// echo_range_checker: distance predictor and result comparator
// Watches the config port, the request channel and the result channel, tracks the arm/edge
// sequence to work out each distance result, and compares results in order.
// ---------------------------------------------------------------------------
module echo_range_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [epr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [epr_pkg::REG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_command,
  input  logic [epr_pkg::TIM_W-1:0]     in_timer_id,
  input  logic [epr_pkg::CH_W-1:0]      in_channel,
  input  logic                          in_wide_counter,
  input  logic [epr_pkg::CAP_W-1:0]     in_capture_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [epr_pkg::DIST_W-1:0]    out_distance_cm,
  input  logic                          out_in_range,
  output int                            fail_count,
  output int                            pending
);
  import epr_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance_cm;
    logic              in_range;
  } range_result_t;

  logic [REG_W-1:0] ticks_per_cm;
  logic [REG_W-1:0] range_limit_cm;
  phase_t           echo_phase;
  logic [TIM_W-1:0] watch_timer;
  logic [CH_W-1:0]  watch_channel;
  logic             watch_wide;
  logic [CAP_W-1:0] rise_count;

  range_result_t expected_ranges[$];
  int            mismatch_count = 0;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // advance the arm/edge sequence by one request, queue a distance if it closes
  task automatic predict_range(input logic cmd, input logic [TIM_W-1:0] tim,
                               input logic [CH_W-1:0] ch, input logic wide,
                               input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] mask;
    logic [CAP_W-1:0] pulse_ticks;
    logic [CAP_W-1:0] whole_cm;
    range_result_t    r;
    mask = watch_wide ? WIDE_MASK : NARROW_MASK;
    if (cmd == CMD_ARM) begin
      watch_timer   = tim;
      watch_channel = ch;
      watch_wide    = wide;
      echo_phase    = PH_RISING;
    end else if (tim == watch_timer && ch == watch_channel) begin
      if (echo_phase == PH_RISING) begin
        rise_count = cap & mask;
        echo_phase = PH_FALLING;
      end else if (echo_phase == PH_FALLING) begin
        pulse_ticks = ((cap & mask) - rise_count) & mask;
        whole_cm = (ticks_per_cm != '0) ? pulse_ticks / CAP_W'(ticks_per_cm) : '0;
        if (whole_cm == '0 || whole_cm > CAP_W'(range_limit_cm)) begin
          r.distance_cm = range_limit_cm;
          r.in_range    = 1'b0;
        end else begin
          r.distance_cm = whole_cm[DIST_W-1:0];
          r.in_range    = 1'b1;
        end
        expected_ranges.push_back(r);
        echo_phase = PH_DONE;
      end
    end
  endtask

  task automatic check_result(input range_result_t got);
    range_result_t want;
    if (expected_ranges.size() == 0) begin
      flag_mismatch($sformatf("unexpected result distance %0d in_range %0b",
                              got.distance_cm, got.in_range));
    end else begin
      want = expected_ranges.pop_front();
      if (got.distance_cm !== want.distance_cm)
        flag_mismatch($sformatf("distance_cm %0d, want %0d",
                                got.distance_cm, want.distance_cm));
      if (got.in_range !== want.in_range)
        flag_mismatch($sformatf("in_range %0b, want %0b", got.in_range, want.in_range));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_cm   = 16'd58;
      range_limit_cm = 16'd400;
      echo_phase     = PH_DONE;
      watch_timer    = '0;
      watch_channel  = '0;
      watch_wide     = 1'b0;
      rise_count     = '0;
      expected_ranges.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SPEED_FACTOR: ticks_per_cm   = cfg_data;
          REG_MAX_RANGE:    range_limit_cm = cfg_data;
          default: ;
        endcase
      end
      // results first: they always belong to requests taken earlier
      if (out_valid && !out_stall) check_result({out_distance_cm, out_in_range});
      if (in_valid && !in_stall)
        predict_range(in_command, in_timer_id, in_channel, in_wide_counter,
                      in_capture_value);
    end
    fail_count <= mismatch_count;
    pending    <= expected_ranges.size();
  end

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for echo_pulse_range_capture_unit
// Directed arm/edge requests, then register settings with random measurement
// sequences, random gaps on both channels and one long result hold-off.
// ---------------------------------------------------------------------------
module tb;
  import epr_pkg::*;

  localparam int SETTLE_CYCLES = 40;   // margin for a closing edge still in the divider
  localparam int HOLD_CYCLES   = 500;  // long receiver hold-off
  localparam int PHASE_ITEMS   = 200;  // counted requests per register setting
  localparam int NUM_PHASES    = 8;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_command;
  logic [TIM_W-1:0]  in_timer_id;
  logic [CH_W-1:0]   in_channel;
  logic              in_wide_counter;
  logic [CAP_W-1:0]  in_capture_value;
  logic              out_valid;
  logic              out_stall;
  logic [DIST_W-1:0] out_distance_cm;
  logic              out_in_range;

  int               fail_count;
  int               pending;
  logic             squeeze_start;   // asks the receiver for its long hold-off
  int               steady_left;     // requests left in a no-gap stretch
  logic [REG_W-1:0] cur_speed;       // settings last written, to aim pulse widths
  logic [REG_W-1:0] cur_limit;

  echo_pulse_range_capture_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_timer_id      (in_timer_id),
    .in_channel       (in_channel),
    .in_wide_counter  (in_wide_counter),
    .in_capture_value (in_capture_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_distance_cm  (out_distance_cm),
    .out_in_range     (out_in_range)
  );

  echo_range_checker range_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_timer_id      (in_timer_id),
    .in_channel       (in_channel),
    .in_wide_counter  (in_wide_counter),
    .in_capture_value (in_capture_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_distance_cm  (out_distance_cm),
    .out_in_range     (out_in_range),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall bursts, mostly short, now and then long; long free
  // runs give stretches with no back-pressure. Once asked, it stalls through one
  // long hold-off so the single result slot fills and the input stalls.
  initial begin
    int  run_left;
    bit  hold_done;
    int  len;
    out_stall = 1'b0;
    run_left  = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_start && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        run_left = 0;
      end else if (run_left == 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        out_stall <= ($urandom_range(0, 3) == 0);
        run_left = len - 1;
      end else begin
        run_left--;
      end
    end
  end

  // Present one request at the current falling edge and hold it until taken.
  // Valid is left high on return; a gap lowers it only when one is chosen, so
  // back-to-back requests never see valid dropped and raised in one step.
  task automatic issue_request(input logic cmd, input logic [TIM_W-1:0] tim,
                               input logic [CH_W-1:0] ch, input logic wide,
                               input logic [CAP_W-1:0] cap);
    int gap;
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_timer_id      <= tim;
    in_channel       <= ch;
    in_wide_counter  <= wide;
    in_capture_value <= cap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    // sender pacing
    if (steady_left > 0) begin
      steady_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      steady_left = $urandom_range(20, 60);
    end else if ($urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Registers only change with the block idle: results drained, then enough
  // cycles for any closing edge still in the divider.
  task automatic program_ranging(input logic [REG_W-1:0] speed,
                                 input logic [REG_W-1:0] limit);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SPEED_FACTOR;
    cfg_data  <= speed;
    @(negedge clk);
    cfg_index <= REG_MAX_RANGE;
    cfg_data  <= limit;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_speed = speed;
    cur_limit = limit;
  endtask

  // occasional edge from another timer or channel inside a measurement
  task automatic maybe_foreign(input logic [TIM_W-1:0] tim, input logic [CH_W-1:0] ch);
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0)
        issue_request(CMD_EDGE, tim ^ TIM_W'($urandom_range(1, 7)), ch,
                      1'($urandom_range(0, 1)), $urandom);
      else
        issue_request(CMD_EDGE, tim, ch ^ CH_W'($urandom_range(1, 3)),
                      1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  // arm, rising edge, falling edge; the pulse width is aimed near the
  // interesting distances of the current setting
  task automatic run_measurement(inout int tally);
    logic [TIM_W-1:0] tim;
    logic [CH_W-1:0]  ch;
    logic             wide;
    logic [CAP_W-1:0] mask;
    logic [CAP_W-1:0] rise;
    logic [CAP_W-1:0] fall;
    logic [63:0]      pulse;
    int unsigned      goal;
    tim  = TIM_W'($urandom_range(0, 7));
    ch   = CH_W'($urandom_range(0, 3));
    wide = 1'($urandom_range(0, 1));
    issue_request(CMD_ARM, tim, ch, wide, $urandom);
    if ($urandom_range(0, 15) == 0) begin
      // abandoned measurement: arm again on a fresh pair
      tim  = TIM_W'($urandom_range(0, 7));
      ch   = CH_W'($urandom_range(0, 3));
      wide = 1'($urandom_range(0, 1));
      issue_request(CMD_ARM, tim, ch, wide, $urandom);
    end
    maybe_foreign(tim, ch);
    rise = $urandom;
    issue_request(CMD_EDGE, tim, ch, 1'($urandom_range(0, 1)), rise);
    maybe_foreign(tim, ch);
    mask = wide ? WIDE_MASK : NARROW_MASK;
    case ($urandom_range(0, 9))
      0:       goal = 0;
      1:       goal = cur_limit;
      2:       goal = cur_limit + 1;
      default: goal = $urandom_range(1, (cur_limit > 0) ? cur_limit : 1);
    endcase
    pulse = 64'(goal) * cur_speed + ((cur_speed > 1) ? $urandom_range(0, cur_speed - 1) : 0);
    if (cur_speed == '0 || $urandom_range(0, 9) == 0) pulse = $urandom;
    // narrow counter: junk in the upper half, which must be dropped
    fall = ((rise + pulse[CAP_W-1:0]) & mask) | ($urandom & ~mask);
    issue_request(CMD_EDGE, tim, ch, 1'($urandom_range(0, 1)), fall);
    if ($urandom_range(0, 9) == 0)
      issue_request(CMD_EDGE, tim, ch, 1'($urandom_range(0, 1)), $urandom);  // late edge
    tally += 3;
  endtask

  // fully random requests; arms among them break running sequences
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      issue_request(($urandom_range(0, 1) == 0) ? CMD_ARM : CMD_EDGE,
                    TIM_W'($urandom_range(0, 7)), CH_W'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), $urandom);
  endtask

  initial begin
    int               items_done;
    logic [REG_W-1:0] speed_set [NUM_PHASES];
    logic [REG_W-1:0] limit_set [NUM_PHASES];
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_SPEED_FACTOR;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_command       = CMD_ARM;
    in_timer_id      = '0;
    in_channel       = '0;
    in_wide_counter  = 1'b0;
    in_capture_value = '0;
    squeeze_start    = 1'b0;
    steady_left      = 0;
    cur_speed        = 16'd58;
    cur_limit        = 16'd400;

    // extremes, zero divisor, zero limit, and two random settings
    speed_set = '{16'd1, 16'hFFFF, 16'd0, 16'd58, 16'd0, 16'd58, 16'd1, 16'd0};
    limit_set = '{16'hFFFF, 16'd1, 16'd400, 16'd0, 16'd0, 16'd400, 16'd1, 16'd0};
    speed_set[4] = REG_W'($urandom_range(1, 65535));
    limit_set[4] = REG_W'($urandom_range(1, 65535));
    speed_set[7] = REG_W'($urandom_range(2, 200));
    limit_set[7] = REG_W'($urandom_range(50, 1000));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed, reset settings (58 ticks/cm, 400 cm) ---
    issue_request(CMD_EDGE, 3'd0, 2'd0, 1'b0, 32'h0000_1000);  // edge with nothing armed
    issue_request(CMD_ARM,  3'd0, 2'd0, 1'b0, 32'hFFFF_FFFF);  // narrow, capture ignored
    issue_request(CMD_EDGE, 3'd1, 2'd0, 1'b0, 32'h0000_0000);  // other timer
    issue_request(CMD_EDGE, 3'd0, 2'd1, 1'b0, 32'h0000_0000);  // other channel
    issue_request(CMD_EDGE, 3'd0, 2'd0, 1'b1, 32'h1234_0010);  // rising, upper half dropped
    issue_request(CMD_EDGE, 3'd0, 2'd0, 1'b0, 32'hABCD_16B8);  // 5800 ticks -> 100 cm
    issue_request(CMD_EDGE, 3'd0, 2'd0, 1'b0, 32'h0000_9000);  // after done: ignored
    issue_request(CMD_ARM,  3'd7, 2'd3, 1'b1, 32'h0000_0000);  // wide counter
    issue_request(CMD_EDGE, 3'd7, 2'd3, 1'b0, 32'hFFFF_FF00);
    issue_request(CMD_EDGE, 3'd7, 2'd3, 1'b1, 32'h0000_1000);  // 32-bit rollover
    issue_request(CMD_ARM,  3'd5, 2'd2, 1'b0, 32'h0000_0000);
    issue_request(CMD_EDGE, 3'd5, 2'd2, 1'b0, 32'h0000_FFF0);
    issue_request(CMD_ARM,  3'd5, 2'd2, 1'b0, 32'h0000_0000);  // re-arm mid measurement
    issue_request(CMD_EDGE, 3'd5, 2'd2, 1'b0, 32'h0000_0010);
    issue_request(CMD_EDGE, 3'd5, 2'd2, 1'b0, 32'h7777_0010);  // zero width: out of range
    issue_request(CMD_ARM,  3'd2, 2'd1, 1'b1, 32'h0000_0000);
    issue_request(CMD_EDGE, 3'd2, 2'd1, 1'b0, 32'h0000_0000);
    issue_request(CMD_EDGE, 3'd2, 2'd1, 1'b0, 32'hFFFF_FFFF);  // far past the limit
    issue_request(CMD_ARM,  3'd4, 2'd0, 1'b0, 32'h0000_0000);
    issue_request(CMD_EDGE, 3'd4, 2'd0, 1'b0, 32'h0000_FFFF);
    issue_request(CMD_EDGE, 3'd4, 2'd0, 1'b0, 32'h0000_5AA5);  // 16-bit wrap, exactly 400
    issue_request(CMD_ARM,  3'd6, 2'd2, 1'b0, 32'h0000_0000);
    issue_request(CMD_EDGE, 3'd6, 2'd2, 1'b0, 32'h0000_0000);
    issue_request(CMD_EDGE, 3'd6, 2'd2, 1'b0, 32'h0000_5ADA);  // 401 cm: out of range

    // --- random measurements under each register setting ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_ranging(speed_set[p], limit_set[p]);
      if (p == 0) squeeze_start <= 1'b1;
      items_done = 0;
      while (items_done < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        else run_measurement(items_done);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/epr_pkg.sv
hdl/epr_divider.sv
hdl/echo_pulse_range_capture_unit.sv
tb/echo_range_checker.sv
tb/tb.sv
